// ----- hdl/sgpl_pkg.sv -----
// Shared types, constants and the divider step for the scaled glyph pixel lookup.
// No dependencies; all other hdl files but sgpl_out_buf use it by scoped names.
package sgpl_pkg;

	// Coordinate and divisor widths.
	localparam int COORD_W = 16;
	localparam int SCALE_W = 8;

	// Quotient bits resolved by each divider stage, and the number of stages.
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = COORD_W / DIV_BITS;

	// Glyph store geometry.
	localparam int STORE_DEPTH = 512;
	localparam int ADDR_W      = 9;

	// Result codes.
	localparam logic [1:0] CLASS_OUTSIDE = 2'd0;
	localparam logic [1:0] CLASS_CLEAR   = 2'd1;
	localparam logic [1:0] CLASS_SET     = 2'd2;

	// Register map, one register per 32-bit word.
	typedef enum logic [2:0] {
		REG_WIDTH     = 3'd0,
		REG_HEIGHT    = 3'd1,
		REG_COL_SHIFT = 3'd2,
		REG_ROW_SHIFT = 3'd3,
		REG_SCALE     = 3'd4
	} reg_idx_t;

	// Per-word control that travels alongside the coordinates.
	typedef struct packed {
		logic              is_query;
		logic [ADDR_W-1:0] byte_index;
		logic [7:0]        byte_value;
	} ctl_t;

	// One lane of the restoring divider: partial remainder and a work word
	// that starts as the dividend and fills with quotient bits from the right.
	typedef struct packed {
		logic [SCALE_W-1:0] rem;
		logic [COORD_W-1:0] work;
	} div_lane_t;

	// Glyph geometry as seen by the lookup stages (already clamped).
	typedef struct packed {
		logic [6:0]        width;
		logic [6:0]        height;
		logic signed [8:0] col_shift;
		logic signed [9:0] row_shift;
	} geom_t;

	// Resolve DIV_BITS quotient bits of one lane.
	function automatic div_lane_t div_step(div_lane_t lane, logic [SCALE_W-1:0] dvs);
		div_lane_t        l;
		logic [SCALE_W:0] t;
		l = lane;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {l.rem, l.work[COORD_W-1]};
			l.work = {l.work[COORD_W-2:0], 1'b0};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				l.work[0] = 1'b1;
			end
			l.rem = t[SCALE_W-1:0];
		end
		return l;
	endfunction

endpackage

// ----- hdl/scaled_glyph_pixel_lookup.sv -----
// Top level of the scaled glyph pixel lookup: register port and pipeline wiring.
// Depends on sgpl_pkg, sgpl_divider, sgpl_lookup and sgpl_out_buf.
//
// Usage. Words enter on the s_axis channel. tuser selects the kind: a load word
// (tuser 0) writes byte_value to glyph store entry byte_index and gives no result;
// a query word (tuser 1) gives one result word on m_axis holding the pixel class
// (0 outside the glyph box, 1 glyph bit clear, 2 glyph bit set) for pixel_x,
// pixel_y of the magnified font box. Results leave in the order of the queries.
// Path: a query's result passes four divider stages, the box test, the store read
// and the output register; the first divider stage loads at the accepting edge.
// Throughput: one word per cycle unless stalled; the 16-bit divide by the scale is
// spread over four stages of four quotient bits, so nothing in the pipeline iterates.
// Stalls: the output register plus a skid stage absorb one extra result; while the
// skid holds a word, s_axis_tready is low and the whole pipeline holds.
// Reset: registers return to width 8, height 8, zero shifts, scale 1; the pipeline
// empties. The glyph store is not cleared: an entry must be loaded before a query
// reads it. The user must see that registers are written over the APB port only
// while the block is idle; the block itself does not enforce this.
module scaled_glyph_pixel_lookup #(
	parameter int MAX_GLYPH_WIDTH  = 64,
	parameter int MAX_GLYPH_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input words.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // byte_index[8:0], byte_value[16:9], pixel_x[32:17], pixel_y[48:33]
	input  logic [0:0]  s_axis_tuser,  // req_type[0]
	// Result words.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // pixel_class[1:0]
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0]        glyph_width_q, glyph_height_q;
	logic signed [8:0] col_shift_q;
	logic signed [9:0] row_shift_q;
	logic [7:0]        scale_q;

	sgpl_pkg::reg_idx_t reg_idx;
	sgpl_pkg::geom_t    geom;
	sgpl_pkg::ctl_t     in_ctl, div_ctl;
	logic [7:0]         dvs;
	logic               en, in_accept, div_valid, res_valid;
	logic [15:0]        div_qx, div_qy;
	logic [1:0]         res_class, out_class;

	assign pready  = 1'b1;
	assign reg_idx = sgpl_pkg::reg_idx_t'(paddr[4:2]);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q  <= 7'd8;
			glyph_height_q <= 7'd8;
			col_shift_q    <= '0;
			row_shift_q    <= '0;
			scale_q        <= 8'd1;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				sgpl_pkg::REG_WIDTH:     glyph_width_q  <= pwdata[6:0];
				sgpl_pkg::REG_HEIGHT:    glyph_height_q <= pwdata[6:0];
				sgpl_pkg::REG_COL_SHIFT: col_shift_q    <= pwdata[8:0];
				sgpl_pkg::REG_ROW_SHIFT: row_shift_q    <= pwdata[9:0];
				sgpl_pkg::REG_SCALE:     scale_q        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_idx)
			sgpl_pkg::REG_WIDTH:     prdata = {25'd0, glyph_width_q};
			sgpl_pkg::REG_HEIGHT:    prdata = {25'd0, glyph_height_q};
			sgpl_pkg::REG_COL_SHIFT: prdata = {23'd0, col_shift_q};
			sgpl_pkg::REG_ROW_SHIFT: prdata = {22'd0, row_shift_q};
			sgpl_pkg::REG_SCALE:     prdata = {24'd0, scale_q};
			default:                 prdata = '0;
		endcase
	end

	// Clamped geometry and the divisor, with a zero scale taken as one.
	always_comb begin
		geom.width = ({2'b00, glyph_width_q} > 9'(MAX_GLYPH_WIDTH)) ?
			7'(MAX_GLYPH_WIDTH) : glyph_width_q;
		geom.height = ({2'b00, glyph_height_q} > 9'(MAX_GLYPH_HEIGHT)) ?
			7'(MAX_GLYPH_HEIGHT) : glyph_height_q;
		geom.col_shift = col_shift_q;
		geom.row_shift = row_shift_q;
		dvs = (scale_q == 8'd0) ? 8'd1 : scale_q;
	end

	// Unpack the input word.
	assign s_axis_tready     = en;
	assign in_accept         = s_axis_tvalid && en;
	assign in_ctl.is_query   = s_axis_tuser[0];
	assign in_ctl.byte_index = s_axis_tdata[8:0];
	assign in_ctl.byte_value = s_axis_tdata[16:9];

	sgpl_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.dvs       (dvs),
		.in_valid  (in_accept),
		.in_ctl    (in_ctl),
		.in_x      (s_axis_tdata[32:17]),
		.in_y      (s_axis_tdata[48:33]),
		.out_valid (div_valid),
		.out_ctl   (div_ctl),
		.out_qx    (div_qx),
		.out_qy    (div_qy)
	);

	sgpl_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.geom      (geom),
		.in_valid  (div_valid),
		.in_ctl    (div_ctl),
		.in_qx     (div_qx),
		.in_qy     (div_qy),
		.res_valid (res_valid),
		.res_class (res_class)
	);

	sgpl_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_class (res_class),
		.en        (en),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_class   (out_class)
	);

	assign m_axis_tdata = {6'd0, out_class};

endmodule

// ----- hdl/sgpl_divider.sv -----
// Four-stage pipelined restoring divider for both pixel coordinates.
// Depends on sgpl_pkg for the lane type and the per-stage division step.
module sgpl_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [sgpl_pkg::SCALE_W-1:0]       dvs,
	input  logic                               in_valid,
	input  sgpl_pkg::ctl_t                     in_ctl,
	input  logic [sgpl_pkg::COORD_W-1:0]       in_x,
	input  logic [sgpl_pkg::COORD_W-1:0]       in_y,
	output logic                               out_valid,
	output sgpl_pkg::ctl_t                     out_ctl,
	output logic [sgpl_pkg::COORD_W-1:0]       out_qx,
	output logic [sgpl_pkg::COORD_W-1:0]       out_qy
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	sgpl_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	sgpl_pkg::div_lane_t x_s1, x_s2, x_s3, x_s4;
	sgpl_pkg::div_lane_t y_s1, y_s2, y_s3, y_s4;
	sgpl_pkg::div_lane_t x_init, y_init;

	// A fresh division starts with a zero remainder.
	assign x_init = '{rem: '0, work: in_x};
	assign y_init = '{rem: '0, work: in_y};

	// Valid bits advance with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Each stage resolves four quotient bits of both coordinates.
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			x_s1   <= sgpl_pkg::div_step(x_init, dvs);
			x_s2   <= sgpl_pkg::div_step(x_s1, dvs);
			x_s3   <= sgpl_pkg::div_step(x_s2, dvs);
			x_s4   <= sgpl_pkg::div_step(x_s3, dvs);
			y_s1   <= sgpl_pkg::div_step(y_init, dvs);
			y_s2   <= sgpl_pkg::div_step(y_s1, dvs);
			y_s3   <= sgpl_pkg::div_step(y_s2, dvs);
			y_s4   <= sgpl_pkg::div_step(y_s3, dvs);
		end
	end

	assign out_valid = valid_s4;
	assign out_ctl   = ctl_s4;
	assign out_qx    = x_s4.work;
	assign out_qy    = y_s4.work;

endmodule

// ----- hdl/sgpl_lookup.sv -----
// Box test, byte addressing and glyph store (stages five and six).
// Depends on sgpl_pkg for the control, geometry types and result codes.
module sgpl_lookup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  sgpl_pkg::geom_t               geom,
	input  logic                          in_valid,
	input  sgpl_pkg::ctl_t                in_ctl,
	input  logic [sgpl_pkg::COORD_W-1:0]  in_qx,
	input  logic [sgpl_pkg::COORD_W-1:0]  in_qy,
	output logic                          res_valid,
	output logic [1:0]                    res_class
);

	logic signed [17:0] bx, by;
	logic               x_in, y_in;
	logic [4:0]         row_bytes;
	logic [11:0]        addr_full;
	logic [sgpl_pkg::ADDR_W-1:0] rd_addr;

	logic                 valid_s5, valid_s6;
	sgpl_pkg::ctl_t       ctl_s5;
	logic                 is_query_s6;
	logic                 in_box_s5, in_box_s6;
	logic [6:0]           bx_s5, by_s5;
	logic [2:0]           bit_s6;
	logic [7:0]           rdata_s6;

	logic [7:0] store_q [sgpl_pkg::STORE_DEPTH];

	// Shifted glyph coordinates and the test against the glyph box.
	always_comb begin
		bx   = $signed({2'b00, in_qx}) + {{9{geom.col_shift[8]}}, geom.col_shift};
		by   = $signed({2'b00, in_qy}) + {{8{geom.row_shift[9]}}, geom.row_shift};
		x_in = !bx[17] && (bx[16:0] < {10'd0, geom.width});
		y_in = !by[17] && (by[16:0] < {10'd0, geom.height});
	end

	// Byte address: row times bytes per row plus the column byte, wrapped to the store.
	always_comb begin
		row_bytes = 5'(({1'b0, geom.width} + 8'd7) >> 3);
		addr_full = {5'd0, by_s5} * {7'd0, row_bytes} + {8'd0, bx_s5[6:3]};
		rd_addr   = addr_full[sgpl_pkg::ADDR_W-1:0];
	end

	// Control of stages five and six.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s5 <= in_valid;
			valid_s6 <= valid_s5;
		end
	end

	// Payload of stages five and six.
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s5      <= in_ctl;
			in_box_s5   <= x_in && y_in;
			bx_s5       <= bx[6:0];
			by_s5       <= by[6:0];
			is_query_s6 <= ctl_s5.is_query;
			in_box_s6   <= in_box_s5;
			bit_s6      <= bx_s5[2:0];
		end
	end

	// Glyph store: load words write, queries read with a registered output.
	always_ff @(posedge clk) begin
		if (en) begin
			if (valid_s5 && !ctl_s5.is_query) begin
				store_q[ctl_s5.byte_index] <= ctl_s5.byte_value;
			end
			rdata_s6 <= store_q[rd_addr];
		end
	end

	// Pick the pixel, leftmost pixel in bit seven.
	always_comb begin
		res_valid = valid_s6 && is_query_s6;
		if (!in_box_s6) begin
			res_class = sgpl_pkg::CLASS_OUTSIDE;
		end else if (rdata_s6[~bit_s6]) begin
			res_class = sgpl_pkg::CLASS_SET;
		end else begin
			res_class = sgpl_pkg::CLASS_CLEAR;
		end
	end

endmodule

// ----- hdl/sgpl_out_buf.sv -----
// Output register with a skid stage; freezes the pipeline while the skid is full.
// Depends on sgpl_pkg only through its users; holds two-bit result words.
module sgpl_out_buf (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  logic [1:0] res_class,
	output logic       en,
	output logic       m_valid,
	input  logic       m_ready,
	output logic [1:0] m_class
);

	logic       out_valid_q, skid_valid_q;
	logic [1:0] out_class_q, skid_class_q;
	logic       take, out_free;

	assign take     = out_valid_q && m_ready;
	assign out_free = !out_valid_q || take;
	assign en       = !skid_valid_q;

	// Occupancy of the output register and the skid stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result words follow the same choices.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_class_q <= skid_class_q;
			end
		end else if (res_valid) begin
			if (out_free) begin
				out_class_q <= res_class;
			end else begin
				skid_class_q <= res_class;
			end
		end
	end

	assign m_valid = out_valid_q;
	assign m_class = out_class_q;

endmodule

// ----- hdl/sgpl_checker.sv -----
// Port-level checks for the scaled glyph pixel lookup, bound to the top level.
// Depends on sgpl_pkg for the result codes and on the top level's port list.
module sgpl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        pready
);

	// A result word holds one of the three pixel classes and no stray bits.
	a_class_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0) &&
		(m_axis_tdata[1:0] == sgpl_pkg::CLASS_OUTSIDE ||
		 m_axis_tdata[1:0] == sgpl_pkg::CLASS_CLEAR ||
		 m_axis_tdata[1:0] == sgpl_pkg::CLASS_SET))
		else $error("result word carries an unknown pixel class");

	// The input side only backs off while a result is waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	// A stalled result word is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result word dropped or changed");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("register port not ready");

endmodule

bind scaled_glyph_pixel_lookup sgpl_checker u_sgpl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.pready        (pready)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for scaled_glyph_pixel_lookup: directed and random load and query words,
// checked against an in-bench pixel class predictor. Depends on sgpl_pkg and the RTL.
module tb;

	localparam int GLYPH_W_MAX      = 64;
	localparam int GLYPH_H_MAX      = 64;
	localparam int SETTLE_CYCLES    = 12;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_PHASES    = 8;
	localparam int ITEMS_PER_PHASE  = 90;

	// Word kinds carried in tuser.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// A register address with nothing behind it.
	localparam logic [4:0] UNMAPPED_ADDR = 5'd28;

	typedef enum logic [1:0] {
		ROW_REG,
		ROW_LOAD,
		ROW_QUERY
	} step_kind_t;

	// One line of the directed table: a register write (a = address, b = value),
	// a load (a = byte index, b = byte) or a query (a = pixel_x, b = pixel_y).
	typedef struct packed {
		step_kind_t  kind;
		logic [31:0] a;
		logic [31:0] b;
		logic        typed;
		logic [1:0]  want;
	} dir_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;  // byte_index[8:0], byte_value[16:9], pixel_x[32:17], pixel_y[48:33]
	logic [0:0]  s_axis_tuser  = '0;  // req_type[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // pixel_class[1:0]
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [4:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	// Mirror of the block's registers and glyph store.
	logic [6:0]        cfg_width     = 7'd8;
	logic [6:0]        cfg_height    = 7'd8;
	logic signed [8:0] cfg_col_shift = '0;
	logic signed [9:0] cfg_row_shift = '0;
	logic [7:0]        cfg_scale     = 8'd1;
	logic [7:0]        glyph_mirror [0:sgpl_pkg::STORE_DEPTH-1];
	bit                loaded       [0:sgpl_pkg::STORE_DEPTH-1];

	logic [1:0] class_queue [$];
	logic [1:0] class_want;
	dir_row_t   dir_rows [$];
	int         err_count   = 0;
	int         cycle_count = 0;
	int         tx_idle_pct = 0;
	int         rx_stall_pct = 0;

	scaled_glyph_pixel_lookup #(
		.MAX_GLYPH_WIDTH (GLYPH_W_MAX),
		.MAX_GLYPH_HEIGHT(GLYPH_H_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Free-running clock.
	initial begin
		forever #1 clk = ~clk;
	end

	// The run ends here if the block stops moving.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		err_count++;
	endtask

	// Maps a pixel to its glyph cell. Returns 0 when the cell lies outside the
	// glyph box, else the store address and the bit position within the byte.
	function automatic bit locate_cell(input logic [15:0] px, input logic [15:0] py,
			output int addr, output int bpos);
		int w, h, s, bx, by, xs, ys;
		w  = (cfg_width > GLYPH_W_MAX) ? GLYPH_W_MAX : int'(cfg_width);
		h  = (cfg_height > GLYPH_H_MAX) ? GLYPH_H_MAX : int'(cfg_height);
		s  = (cfg_scale == 8'd0) ? 1 : int'(cfg_scale);
		xs = cfg_col_shift;
		ys = cfg_row_shift;
		bx = int'(px) / s + xs;
		by = int'(py) / s + ys;
		addr = 0;
		bpos = 0;
		if (bx < 0 || bx >= w || by < 0 || by >= h)
			return 1'b0;
		addr = (by * ((w + 7) / 8) + bx / 8) % sgpl_pkg::STORE_DEPTH;
		// Leftmost pixel sits in bit 7.
		bpos = 7 - bx % 8;
		return 1'b1;
	endfunction

	function automatic logic [1:0] predict_class(input logic [15:0] px, input logic [15:0] py);
		int addr, bpos;
		if (!locate_cell(px, py, addr, bpos))
			return sgpl_pkg::CLASS_OUTSIDE;
		return glyph_mirror[addr][bpos] ? sgpl_pkg::CLASS_SET : sgpl_pkg::CLASS_CLEAR;
	endfunction

	// Register writes land in the mirror; unmapped indexes are dropped.
	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] v);
		case (idx)
			sgpl_pkg::REG_WIDTH:     cfg_width     = v[6:0];
			sgpl_pkg::REG_HEIGHT:    cfg_height    = v[6:0];
			sgpl_pkg::REG_COL_SHIFT: cfg_col_shift = v[8:0];
			sgpl_pkg::REG_ROW_SHIFT: cfg_row_shift = v[9:0];
			sgpl_pkg::REG_SCALE:     cfg_scale     = v[7:0];
			default: ;
		endcase
	endfunction

	function automatic logic [4:0] reg_addr(input sgpl_pkg::reg_idx_t r);
		return {r, 2'b00};
	endfunction

	// The same address as a table entry.
	function automatic logic [31:0] reg_row(input sgpl_pkg::reg_idx_t r);
		return {27'd0, r, 2'b00};
	endfunction

	function automatic void add_row(input step_kind_t kind, input logic [31:0] a,
			input logic [31:0] b, input logic typed, input logic [1:0] want);
		dir_row_t row;
		row.kind  = kind;
		row.a     = a;
		row.b     = b;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endfunction

	// Results are taken at random; the stall rate follows the current phase.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Each result word is held against the oldest pixel class waiting.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (class_queue.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected",
					m_axis_tdata[1:0]));
			end else begin
				class_want = class_queue.pop_front();
				if (m_axis_tdata[1:0] !== class_want)
					report_mismatch($sformatf("pixel_class %0d, expected %0d",
						m_axis_tdata[1:0], class_want));
			end
		end
	end

	// Sends one word, with random idle cycles first. Starts and ends at a falling edge.
	task automatic push_word(input logic req, input logic [8:0] idx, input logic [7:0] val,
			input logic [15:0] px, input logic [15:0] py, input logic typed,
			input logic [1:0] want);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {7'd0, py, px, val, idx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (req == REQ_LOAD) begin
			glyph_mirror[idx] = val;
			loaded[idx]       = 1'b1;
		end else begin
			class_queue.push_back(typed ? want : predict_class(px, py));
		end
		@(negedge clk);
	endtask

	// A query whose cell was never loaded gets a load of that cell first.
	task automatic issue_query(input logic [15:0] px, input logic [15:0] py,
			input logic typed, input logic [1:0] want);
		int addr, bpos;
		if (locate_cell(px, py, addr, bpos) && !loaded[addr])
			push_word(REQ_LOAD, addr[8:0], 8'($urandom_range(255)), 16'($urandom),
				16'($urandom), 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		push_word(REQ_QUERY, 9'($urandom_range(511)), 8'($urandom_range(255)), px, py,
			typed, want);
	endtask

	// Stops sending and waits for the pipeline to empty, loads included.
	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		while (class_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Setup and access phases, then the register port goes idle before the task returns.
	task automatic reg_write(input logic [4:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		apply_reg(addr[4:2], data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_geometry(input int w, input int h, input int c, input int r,
			input int s);
		reg_write(reg_addr(sgpl_pkg::REG_WIDTH), w & 32'h7f);
		reg_write(reg_addr(sgpl_pkg::REG_HEIGHT), h & 32'h7f);
		reg_write(reg_addr(sgpl_pkg::REG_COL_SHIFT), c & 32'h1ff);
		reg_write(reg_addr(sgpl_pkg::REG_ROW_SHIFT), r & 32'h3ff);
		reg_write(reg_addr(sgpl_pkg::REG_SCALE), s & 32'hff);
	endtask

	// One random phase: a fresh geometry, one idling pattern, loads mixed with queries.
	task automatic run_phase(input int ph);
		int w, h, c, r, s, we, he, se, rb, tx, ty, pxv, pyv, xs, ys, k;
		settle_idle();
		case (ph)
			0: begin w = 8; h = 8; c = 0; r = 0; s = 1; end
			1: begin w = 64; h = 64; c = 0; r = 0; s = 1; end
			2: begin w = 127; h = 100; c = -1; r = 2; s = 0; end
			3: begin
				w = $urandom_range(1, 64);
				h = $urandom_range(1, 64);
				c = int'($urandom_range(6)) - 3;
				r = int'($urandom_range(6)) - 3;
				s = 255;
			end
			default: begin
				w = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 40);
				h = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 40);
				if ($urandom_range(3) == 0) begin
					c = int'($urandom_range(511)) - 256;
					r = int'($urandom_range(1023)) - 512;
				end else begin
					c = int'($urandom_range(8)) - 4;
					r = int'($urandom_range(8)) - 4;
				end
				case ($urandom_range(3))
					0:       s = ($urandom_range(1) == 0) ? 0 : 255;
					1:       s = $urandom_range(5, 255);
					default: s = $urandom_range(1, 4);
				endcase
			end
		endcase
		program_geometry(w, h, c, r, s);

		case (ph % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
			default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
		endcase

		we = (cfg_width > GLYPH_W_MAX) ? GLYPH_W_MAX : int'(cfg_width);
		he = (cfg_height > GLYPH_H_MAX) ? GLYPH_H_MAX : int'(cfg_height);
		se = (cfg_scale == 8'd0) ? 1 : int'(cfg_scale);
		rb = (we + 7) / 8;
		xs = cfg_col_shift;
		ys = cfg_row_shift;

		for (k = 0; k < ITEMS_PER_PHASE; k++) begin
			// Once in the run the sender holds off until every result is back.
			if (ph == 5 && k == ITEMS_PER_PHASE / 2)
				settle_idle();
			if ($urandom_range(99) < 30) begin
				if (he > 0 && rb > 0 && $urandom_range(9) < 7)
					pxv = ($urandom_range(he - 1) * rb + $urandom_range(rb - 1)) %
						sgpl_pkg::STORE_DEPTH;
				else
					pxv = $urandom_range(sgpl_pkg::STORE_DEPTH - 1);
				push_word(REQ_LOAD, 9'(pxv), 8'($urandom_range(255)), 16'($urandom),
					16'($urandom), 1'b0, sgpl_pkg::CLASS_OUTSIDE);
			end else begin
				// Aim near the glyph box so that edges and inner bits are hit often.
				tx  = int'($urandom_range(we + 3)) - 2;
				ty  = int'($urandom_range(he + 3)) - 2;
				pxv = (tx - xs) * se + int'($urandom_range(se - 1));
				pyv = (ty - ys) * se + int'($urandom_range(se - 1));
				if (pxv < 0 || pxv > 65535 || $urandom_range(9) == 0)
					pxv = $urandom_range(65535);
				if (pyv < 0 || pyv > 65535 || $urandom_range(9) == 0)
					pyv = $urandom_range(65535);
				issue_query(16'(pxv), 16'(pyv), 1'b0, sgpl_pkg::CLASS_OUTSIDE);
			end
		end
	endtask

	// Main sequence: reset, directed table, random phases, final drain.
	initial begin
		int k, waited;

		// Reset geometry: width 8, height 8, no shift, scale 1.
		add_row(ROW_LOAD,  0,     32'h80, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_LOAD,  7,     32'h01, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_LOAD,  511,   32'hff, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 0,     0,      1'b1, sgpl_pkg::CLASS_SET);
		add_row(ROW_QUERY, 1,     0,      1'b1, sgpl_pkg::CLASS_CLEAR);
		add_row(ROW_QUERY, 7,     7,      1'b1, sgpl_pkg::CLASS_SET);
		add_row(ROW_QUERY, 6,     7,      1'b1, sgpl_pkg::CLASS_CLEAR);
		add_row(ROW_QUERY, 8,     0,      1'b1, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 0,     8,      1'b1, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 65535, 65535,  1'b1, sgpl_pkg::CLASS_OUTSIDE);
		// Oversize glyph: clamped to 64 by 64, so the last cell is store entry 511.
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_WIDTH),  127, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_HEIGHT), 127, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 63, 63, 1'b1, sgpl_pkg::CLASS_SET);
		add_row(ROW_QUERY, 64, 63, 1'b1, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 63, 64, 1'b1, sgpl_pkg::CLASS_OUTSIDE);
		// A scale of zero behaves as a scale of one.
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_SCALE), 0, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 63, 63, 1'b1, sgpl_pkg::CLASS_SET);
		// Largest scale with the most negative shifts, then the most positive ones.
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_SCALE),     255,     1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_COL_SHIFT), 32'h100, 1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_ROW_SHIFT), 32'h200, 1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 65535, 65535, 1'b1, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_COL_SHIFT), 32'h0ff, 1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_ROW_SHIFT), 32'h1ff, 1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 0, 0, 1'b1, sgpl_pkg::CLASS_OUTSIDE);
		// A write to an unmapped address must leave every register alone.
		add_row(ROW_REG, {27'd0, UNMAPPED_ADDR}, 32'hffff_ffff, 1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 300, 70000 % 65536, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		// A zero-width glyph has no inside at all.
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_COL_SHIFT), 0, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_ROW_SHIFT), 0, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_SCALE),     1, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_WIDTH),     0, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 0, 0, 1'b1, sgpl_pkg::CLASS_OUTSIDE);
		// Two-byte rows, scale 2 and a negative column shift.
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_WIDTH),     16,      1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_HEIGHT),    4,       1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_SCALE),     2,       1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_REG, reg_row(sgpl_pkg::REG_COL_SHIFT), 32'h1ff, 1'b0,
			sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 10, 4, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 2,  7, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 34, 7, 1'b0, sgpl_pkg::CLASS_OUTSIDE);
		add_row(ROW_QUERY, 33, 6, 1'b0, sgpl_pkg::CLASS_OUTSIDE);

		foreach (loaded[i])
			loaded[i] = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < dir_rows.size(); k++) begin
			case (dir_rows[k].kind)
				ROW_REG: begin
					settle_idle();
					reg_write(dir_rows[k].a[4:0], dir_rows[k].b);
				end
				ROW_LOAD:
					push_word(REQ_LOAD, dir_rows[k].a[8:0], dir_rows[k].b[7:0],
						16'($urandom), 16'($urandom), 1'b0, sgpl_pkg::CLASS_OUTSIDE);
				default:
					issue_query(dir_rows[k].a[15:0], dir_rows[k].b[15:0],
						dir_rows[k].typed, dir_rows[k].want);
			endcase
		end

		for (k = 0; k < RANDOM_PHASES; k++)
			run_phase(k);

		// Drain what is still in flight, then allow for stray words.
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (class_queue.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (class_queue.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", class_queue.size()));

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
